### sv/llf_pkg.sv
// ============================================================================
// llf_pkg: shared types and constants of the lead-lag filter
// Beat formats of both channels, item kind codes, register indexes and the
// widths of the serial datapath.
// ============================================================================
package llf_pkg;

    // Field widths
    localparam int DATA_W   = 32;   // Q16.16 values and coefficients
    localparam int DT_W     = 24;   // Q4.20 step length
    localparam int KIND_W   = 2;
    localparam int FRAC_W   = 16;   // fraction bits of a Q16.16 value

    // Scaled terms carry 36 fraction bits: c*2^21 + dt*c
    localparam int TWO_SHIFT = 21;  // 2.0 in Q4.20
    localparam int SCALE_W   = DATA_W + DT_W;     // dt*c, signed
    localparam int WIDE_W    = SCALE_W + 1;       // sums of two scaled terms, signed
    localparam int MAG_W     = WIDE_W - 1;        // magnitude of a wide term

    // Divider: quotient bits 32..0 of floor(n*2^16/d)
    localparam int QUO_W      = DATA_W + 1;
    localparam int HUGE_SHIFT = QUO_W - FRAC_W;   // low numerator bits shifted in

    // Output accumulation
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_LANES = 3;

    // Shared step counter
    localparam int CNT_W = $clog2(QUO_W);

    // Configuration port
    localparam int NUM_REGS = 5;
    localparam int ADDR_W   = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Item kinds
    localparam t_kind KIND_UPDATE    = 2'd0;
    localparam t_kind KIND_OVERWRITE = 2'd1;
    localparam t_kind KIND_RESTART   = 2'd2;

    // Register indexes
    localparam t_reg_idx REG_LEAD_NUM  = 3'd0;
    localparam t_reg_idx REG_CONST_NUM = 3'd1;
    localparam t_reg_idx REG_LAG_DEN   = 3'd2;
    localparam t_reg_idx REG_CONST_DEN = 3'd3;
    localparam t_reg_idx REG_INIT_OUT  = 3'd4;

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] sample;
        logic [DT_W-1:0]          time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     updated;
        logic                     bad_denominator;
        logic                     saturated;
    } t_out_item;

endpackage

### sv/lead_lag_filter_tustin_top.sv
// ============================================================================
// lead_lag_filter_tustin_top: first-order lead-lag filter, Tustin discretized
// Filters (c1*s+c2)/(c3*s+c4) with a per-item time step using bit-serial
// multipliers and a shared one-bit-per-cycle restoring divider.
// ============================================================================
//
//  Channel   Direction  Handshake                     Beat
//  --------  ---------  ----------------------------  -----------------------
//  in        input      i_in_valid / o_in_stall       t_in_item  (i_in_data)
//  out       output     o_out_valid / i_out_stall     t_out_item (o_out_data)
//  config    input      psel, penable, pwrite, pready five 32-bit registers
//
//  A filter update with a nonzero step runs dt-serial scaling, three passes
//  through the shared restoring divider (one quotient bit per cycle), and the
//  coefficient-serial output multipliers; the divider passes take the largest
//  share of that work. Overwrite, restart, zero-step and unused kinds go
//  straight to delivery; a zero denominator ends an update in the form step,
//  after the scaling. Reset is synchronous and active low; it clears the
//  registers and the filter state. The result sits in an output register, so a
//  stall on the output holds that beat while the next item is accepted.
//
module lead_lag_filter_tustin_top
    import llf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_FORM,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_COEF,
        S_MUL_LOAD,
        S_MUL,
        S_SUM,
        S_FIN,
        S_DELIVER
    } t_state;

    localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(DT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(DATA_W - 1);
    localparam logic [1:0]       LANE_LAST  = 2'(NUM_LANES - 1);
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    // Control
    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [1:0]           r_lane;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            r_res;
    logic                 r_clip;

    // Configuration and filter state
    logic [DATA_W-1:0]    r_cfg [NUM_REGS];
    logic [DATA_W-1:0]    r_last_in;
    logic [DATA_W-1:0]    r_last_out;
    logic [DATA_W-1:0]    r_held;
    logic [DATA_W-1:0]    r_sample;

    // dt-serial scaling of c4 and c2
    logic [DT_W-1:0]      r_dt;
    logic [SCALE_W-1:0]   r_c4_mc;
    logic [SCALE_W-1:0]   r_c2_mc;
    logic [SCALE_W-1:0]   r_c4_acc;
    logic [SCALE_W-1:0]   r_c2_acc;

    // Divider
    logic [WIDE_W-1:0]    r_num [NUM_LANES];
    logic [MAG_W-1:0]     r_den_mag;
    logic                 r_den_neg;
    logic [MAG_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_dvd;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_neg;
    logic                 r_huge;
    logic [DATA_W-1:0]    r_coef [NUM_LANES];

    // Output multipliers
    logic [PROD_W-1:0]    r_mc [NUM_LANES];
    logic [DATA_W-1:0]    r_mp [NUM_LANES];
    logic [PROD_W-1:0]    r_pacc [NUM_LANES];
    logic [SUM_W-1:0]     r_sum;

    // Combinational terms
    logic                 w_cfg_wr;
    t_reg_idx             w_cfg_idx;
    logic [WIDE_W-1:0]    w_c1w;
    logic [WIDE_W-1:0]    w_c3w;
    logic [WIDE_W-1:0]    w_p4;
    logic [WIDE_W-1:0]    w_p2;
    logic [WIDE_W-1:0]    w_den;
    logic [WIDE_W-1:0]    w_den_inv;
    logic [MAG_W-1:0]     w_den_mag;
    logic [WIDE_W-1:0]    w_num_inv;
    logic [MAG_W-1:0]     w_n_mag;
    logic [MAG_W-1:0]     w_n_top;
    logic [MAG_W:0]       w_shift;
    logic [MAG_W+1:0]     w_diff;
    logic                 w_ge;
    logic                 w_pos_over;
    logic                 w_neg_over;
    logic [DATA_W-1:0]    w_coef;
    logic                 w_coef_clip;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-FRAC_W-1:0] w_y;
    logic                 w_y_ok;
    logic [DATA_W-1:0]    w_y_sat;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[ADDR_W-1:2];
    assign prdata    = (w_cfg_idx <= REG_INIT_OUT) ? r_cfg[w_cfg_idx] : '0;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Denominator and numerators with 36 fraction bits
    always_comb begin
        w_c1w = {{(WIDE_W-DATA_W-TWO_SHIFT){r_cfg[REG_LEAD_NUM][DATA_W-1]}},
                 r_cfg[REG_LEAD_NUM], {TWO_SHIFT{1'b0}}};
        w_c3w = {{(WIDE_W-DATA_W-TWO_SHIFT){r_cfg[REG_LAG_DEN][DATA_W-1]}},
                 r_cfg[REG_LAG_DEN], {TWO_SHIFT{1'b0}}};
        w_p4      = {r_c4_acc[SCALE_W-1], r_c4_acc};
        w_p2      = {r_c2_acc[SCALE_W-1], r_c2_acc};
        w_den     = w_c3w + w_p4;
        w_den_inv = -w_den;
        w_den_mag = w_den[WIDE_W-1] ? w_den_inv[MAG_W-1:0] : w_den[MAG_W-1:0];
    end

    // Numerator magnitude and one restoring divider step
    always_comb begin
        w_num_inv = -r_num[0];
        w_n_mag   = r_num[0][WIDE_W-1] ? w_num_inv[MAG_W-1:0] : r_num[0][MAG_W-1:0];
        w_n_top   = {{HUGE_SHIFT{1'b0}}, w_n_mag[MAG_W-1:HUGE_SHIFT]};
        w_shift   = {r_rem, r_dvd[QUO_W-1]};
        w_diff    = {1'b0, w_shift} - {2'b00, r_den_mag};
        w_ge      = ~w_diff[MAG_W+1];
    end

    // Signed, saturated Q16.16 coefficient from the quotient magnitude
    always_comb begin
        w_pos_over = r_huge | r_quo[QUO_W-1] | r_quo[DATA_W-1];
        w_neg_over = r_huge | r_quo[QUO_W-1] |
                     (r_quo[DATA_W-1] & (|r_quo[DATA_W-2:0]));
        if (r_neg) begin
            w_coef      = w_neg_over ? SAT_MIN : -r_quo[DATA_W-1:0];
            w_coef_clip = w_neg_over;
        end else begin
            w_coef      = w_pos_over ? SAT_MAX : r_quo[DATA_W-1:0];
            w_coef_clip = w_pos_over;
        end
    end

    // Sum of the three products, rounded half up and saturated
    always_comb begin
        w_sum = {{2{r_pacc[0][PROD_W-1]}}, r_pacc[0]} +
                {{2{r_pacc[1][PROD_W-1]}}, r_pacc[1]} +
                {{2{r_pacc[2][PROD_W-1]}}, r_pacc[2]} + ROUND_HALF;
        w_y    = r_sum[SUM_W-1:FRAC_W];
        w_y_ok = (&w_y[SUM_W-FRAC_W-1:DATA_W-1]) | ~(|w_y[SUM_W-FRAC_W-1:DATA_W-1]);
        if (w_y_ok) begin
            w_y_sat = w_y[DATA_W-1:0];
        end else begin
            w_y_sat = w_y[SUM_W-FRAC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
            r_last_in   <= '0;
            r_last_out  <= '0;
            r_held      <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else begin
            if (w_cfg_wr && (w_cfg_idx <= REG_INIT_OUT)) begin
                r_cfg[w_cfg_idx] <= pwdata;
            end

            // The downstream side takes the waiting beat; a result that is
            // ready to move in refills the register in the same cycle.
            if (r_out_valid && !i_out_stall && (r_state != S_DELIVER)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sample                  <= i_in_data.sample;
                        r_res.updated             <= 1'b0;
                        r_res.bad_denominator     <= 1'b0;
                        r_res.saturated           <= 1'b0;
                        case (i_in_data.kind)
                            KIND_UPDATE: begin
                                r_res.filtered <= r_held;
                                if (i_in_data.time_step != '0) begin
                                    r_dt     <= i_in_data.time_step;
                                    r_c4_mc  <= {{DT_W{r_cfg[REG_CONST_DEN][DATA_W-1]}},
                                                 r_cfg[REG_CONST_DEN]};
                                    r_c2_mc  <= {{DT_W{r_cfg[REG_CONST_NUM][DATA_W-1]}},
                                                 r_cfg[REG_CONST_NUM]};
                                    r_c4_acc <= '0;
                                    r_c2_acc <= '0;
                                    r_clip   <= 1'b0;
                                    r_cnt    <= '0;
                                    r_state  <= S_SCALE;
                                end else begin
                                    r_state  <= S_DELIVER;
                                end
                            end
                            KIND_OVERWRITE: begin
                                r_held         <= i_in_data.sample;
                                r_res.filtered <= i_in_data.sample;
                                r_state        <= S_DELIVER;
                            end
                            KIND_RESTART: begin
                                r_held         <= r_cfg[REG_INIT_OUT];
                                r_last_out     <= r_cfg[REG_INIT_OUT];
                                r_last_in      <= '0;
                                r_res.filtered <= r_cfg[REG_INIT_OUT];
                                r_state        <= S_DELIVER;
                            end
                            default: begin
                                r_res.filtered <= r_held;
                                r_state        <= S_DELIVER;
                            end
                        endcase
                    end
                end

                // dt*c4 and dt*c2, one bit of dt per cycle
                S_SCALE: begin
                    if (r_dt[0]) begin
                        r_c4_acc <= r_c4_acc + r_c4_mc;
                        r_c2_acc <= r_c2_acc + r_c2_mc;
                    end
                    r_c4_mc <= r_c4_mc << 1;
                    r_c2_mc <= r_c2_mc << 1;
                    r_dt    <= r_dt >> 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == SCALE_LAST) begin
                        r_state <= S_FORM;
                    end
                end

                // Denominator, the three numerators and the zero-denominator check
                S_FORM: begin
                    r_den_mag <= w_den_mag;
                    r_den_neg <= w_den[WIDE_W-1];
                    r_num[0]  <= w_c1w + w_p2;
                    r_num[1]  <= w_p2 - w_c1w;
                    r_num[2]  <= w_c3w - w_p4;
                    r_lane    <= '0;
                    if (w_den == '0) begin
                        r_res.bad_denominator <= 1'b1;
                        r_state               <= S_DELIVER;
                    end else begin
                        r_state <= S_DIV_LOAD;
                    end
                end

                // Start one division: the top numerator bits form the first
                // partial remainder, the rest are shifted in one per cycle.
                S_DIV_LOAD: begin
                    r_neg  <= r_num[0][WIDE_W-1] ^ r_den_neg;
                    r_huge <= (w_n_top >= r_den_mag);
                    r_rem  <= w_n_top;
                    r_dvd  <= {w_n_mag[HUGE_SHIFT-1:0], {FRAC_W{1'b0}}};
                    r_quo  <= '0;
                    r_cnt  <= '0;
                    for (int i = 0; i < NUM_LANES - 1; i++) begin
                        r_num[i] <= r_num[i+1];
                    end
                    r_state <= S_DIV_RUN;
                end

                // One quotient bit per cycle
                S_DIV_RUN: begin
                    r_rem <= w_ge ? w_diff[MAG_W-1:0] : w_shift[MAG_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_COEF;
                    end
                end

                // Store the coefficient; coefficients shift in as ca, cb, cc
                S_COEF: begin
                    for (int i = 0; i < NUM_LANES - 1; i++) begin
                        r_coef[i] <= r_coef[i+1];
                    end
                    r_coef[NUM_LANES-1] <= w_coef;
                    r_clip              <= r_clip | w_coef_clip;
                    if (r_lane == LANE_LAST) begin
                        r_state <= S_MUL_LOAD;
                    end else begin
                        r_lane  <= r_lane + 1'b1;
                        r_state <= S_DIV_LOAD;
                    end
                end

                S_MUL_LOAD: begin
                    r_mc[0] <= {{DATA_W{r_sample[DATA_W-1]}}, r_sample};
                    r_mc[1] <= {{DATA_W{r_last_in[DATA_W-1]}}, r_last_in};
                    r_mc[2] <= {{DATA_W{r_last_out[DATA_W-1]}}, r_last_out};
                    for (int i = 0; i < NUM_LANES; i++) begin
                        r_mp[i]   <= r_coef[i];
                        r_pacc[i] <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end

                // Three signed products, one coefficient bit per cycle; the
                // sign bit carries negative weight.
                S_MUL: begin
                    for (int i = 0; i < NUM_LANES; i++) begin
                        if (r_mp[i][0]) begin
                            r_pacc[i] <= (r_cnt == MUL_LAST) ? r_pacc[i] - r_mc[i]
                                                             : r_pacc[i] + r_mc[i];
                        end
                        r_mc[i] <= r_mc[i] << 1;
                        r_mp[i] <= r_mp[i] >> 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= S_SUM;
                    end
                end

                S_SUM: begin
                    r_sum   <= w_sum;
                    r_state <= S_FIN;
                end

                // Commit the new output and previous values
                S_FIN: begin
                    r_held                <= w_y_sat;
                    r_last_out            <= w_y_sat;
                    r_last_in             <= r_sample;
                    r_res.filtered        <= w_y_sat;
                    r_res.updated         <= 1'b1;
                    r_res.saturated       <= r_clip | ~w_y_ok;
                    r_state               <= S_DELIVER;
                end

                // Move the result into the output register once it is free
                S_DELIVER: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
